/* sv/cgt_pkg.sv */
// ----------------------------------------------------------------------------
// cgt_pkg
// Shared types and constants of the completion group tracker: transaction
// payloads, status codes, command codes and builder control/status bundles.
// ----------------------------------------------------------------------------
package cgt_pkg;

    localparam int GROUPS_DEF  = 16;
    localparam int MEMBERS_DEF = 8;
    localparam int ID_BITS_DEF = 16;

    localparam int FIELD_ID_W = 16;
    localparam int RESULT_W   = 8;
    localparam int CNT_W      = 4;

    localparam logic [CNT_W-1:0] COUNT_MAX = 4'd15;

    localparam logic CMD_ADD      = 1'b0;
    localparam logic CMD_COMPLETE = 1'b1;

    typedef enum logic [2:0] {
        ST_EMPTY_OK     = 3'd0,
        ST_SINGLE       = 3'd1,
        ST_GROUP_MADE   = 3'd2,
        ST_ADD_FAILED   = 3'd3,
        ST_ACCEPTED     = 3'd4,
        ST_FINISHED     = 3'd5,
        ST_NOT_ACCEPTED = 3'd6
    } t_status;

    typedef struct packed {
        logic                  command;
        logic [FIELD_ID_W-1:0] item_id;
        logic [FIELD_ID_W-1:0] group_id;
        logic                  last_member;
        logic                  empty_list;
        logic [RESULT_W-1:0]   action_result;
    } t_cmd_item;

    typedef struct packed {
        t_status               status;
        logic [FIELD_ID_W-1:0] reported_id;
        logic [RESULT_W-1:0]   reported_result;
    } t_result;

    typedef struct packed {
        logic add;
        logic close;
        logic alloc;
        logic alloc_ovf;
    } t_bld_ctl;

    typedef struct packed {
        logic fresh;
        logic single;
        logic ovf;
    } t_bld_sts;

endpackage

/* sv/cgt_row_ram.sv */
// ----------------------------------------------------------------------------
// cgt_row_ram
// Group row memory: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module cgt_row_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/cgt_list_builder.sv */
// ----------------------------------------------------------------------------
// cgt_list_builder
// Open add list: member row under construction, member count, target slot
// and overflow flag. Merges duplicate members and flags a full row.
// ----------------------------------------------------------------------------
module cgt_list_builder #(
    parameter int MEMBERS = 8,
    parameter int ID_BITS = 16,
    parameter int AW      = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cgt_pkg::t_bld_ctl                 i_ctl,
    input  logic [AW-1:0]                     i_slot,
    input  logic [ID_BITS-1:0]                i_id,
    output cgt_pkg::t_bld_sts                 o_sts,
    output logic [AW-1:0]                     o_slot,
    output logic [MEMBERS-1:0]                o_row_valid,
    output logic [MEMBERS-1:0][ID_BITS-1:0]   o_row_keys
);
    import cgt_pkg::*;

    logic [CNT_W-1:0]               r_count, n_count;
    logic                           r_ovf, n_ovf;
    logic [AW-1:0]                  r_slot;
    logic [MEMBERS-1:0]             r_valid, n_valid;
    logic [MEMBERS-1:0][ID_BITS-1:0] r_keys, n_keys;
    logic [MEMBERS-1:0]             hit;
    logic                           has_free;
    logic [MEMBERS-1:0]             free_sel;

    always_comb begin
        hit      = '0;
        free_sel = '0;
        has_free = 1'b0;
        for (int m = 0; m < MEMBERS; m++) begin
            hit[m] = r_valid[m] && (r_keys[m] == i_id);
            if (!r_valid[m] && !has_free) begin
                free_sel[m] = 1'b1;
                has_free    = 1'b1;
            end
        end
    end

    always_comb begin
        n_count = (r_count < COUNT_MAX) ? r_count + 1'b1 : r_count;
        n_ovf   = r_ovf;
        n_valid = r_valid;
        n_keys  = r_keys;
        if (!r_ovf && !(|hit)) begin
            if (!has_free) begin
                n_ovf = 1'b1;
            end else begin
                n_valid = r_valid | free_sel;
                for (int m = 0; m < MEMBERS; m++) begin
                    if (free_sel[m]) begin
                        n_keys[m] = i_id;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_slot  <= '0;
            r_valid <= '0;
        end else if (i_ctl.close) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_slot  <= '0;
            r_valid <= '0;
        end else if (i_ctl.alloc) begin
            r_slot  <= i_slot;
            r_ovf   <= i_ctl.alloc_ovf;
        end else if (i_ctl.add) begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.add && !i_ctl.close) begin
            r_keys <= n_keys;
        end
    end

    assign o_sts.fresh  = (r_count == '0);
    assign o_sts.single = (n_count == CNT_W'(1));
    assign o_sts.ovf    = n_ovf;
    assign o_slot       = r_slot;
    assign o_row_valid  = n_valid;
    assign o_row_keys   = n_keys;

endmodule

/* sv/completion_group_tracker_unit.sv */
// ----------------------------------------------------------------------------
// completion_group_tracker_unit
// Joins lists of member ids under a composite id and tracks their completion.
//
//   channel   signals                 handshake
//   command   start, busy, i_item     taken when start=1 and busy=0
//   result    o_strobe, o_result      one cycle, no backpressure
//
// Add member: busy in S_ADD, preceded on the first member of a list by a
// free-slot search in S_ALLOC over the group valid flags.
// Completion: busy in S_SCAN, one group row read from the row memory per
// cycle in slot order until the member is found or the last slot is read.
// Reset clears the valid flags and the open list; no memory clearing pass.
// The result strobes in the first idle cycle, which can also take the next
// transaction; results cannot be stalled.
// ----------------------------------------------------------------------------
module completion_group_tracker_unit #(
    parameter int GROUPS  = cgt_pkg::GROUPS_DEF,
    parameter int MEMBERS = cgt_pkg::MEMBERS_DEF,
    parameter int ID_BITS = cgt_pkg::ID_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  cgt_pkg::t_cmd_item i_item,
    output logic               o_strobe,
    output cgt_pkg::t_result   o_result
);
    import cgt_pkg::*;

    localparam int AW    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int KW    = MEMBERS * ID_BITS;
    localparam int RW    = ID_BITS + 2 * MEMBERS + KW;
    localparam logic [AW-1:0] LAST_SLOT = AW'(GROUPS - 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ALLOC = 4'b0010,
        S_ADD   = 4'b0100,
        S_SCAN  = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    t_cmd_item           r_in;
    logic [AW-1:0]       r_scan, n_scan;
    logic                r_ev_on, n_ev_on;
    logic [AW-1:0]       r_ev_idx, n_ev_idx;
    logic [GROUPS-1:0]   r_gvalid, n_gvalid;
    logic                r_strobe, n_strobe;
    t_result             r_out, n_out;

    logic [ID_BITS+FIELD_ID_W-1:0] item_wide, gid_wide;
    logic [ID_BITS-1:0]  item_key, gid_key;
    logic                accept;

    t_bld_ctl            bld_ctl;
    t_bld_sts            bld_sts;
    logic [AW-1:0]       bld_slot;
    logic [MEMBERS-1:0]  bld_valid;
    logic [MEMBERS-1:0][ID_BITS-1:0] bld_keys;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [RW-1:0]       ram_wdata;
    logic [RW-1:0]       ram_rdata;

    logic [ID_BITS-1:0]  rd_gkey;
    logic [MEMBERS-1:0]  rd_valid, rd_done, rd_hit, new_done;
    logic [MEMBERS-1:0][ID_BITS-1:0] rd_keys;
    logic                row_found, row_pending;

    function automatic logic [FIELD_ID_W-1:0] key_to_field(input logic [ID_BITS-1:0] k);
        logic [ID_BITS+FIELD_ID_W-1:0] w;
        w = {{FIELD_ID_W{1'b0}}, k};
        return w[FIELD_ID_W-1:0];
    endfunction

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    assign item_wide = {{ID_BITS{1'b0}}, r_in.item_id};
    assign gid_wide  = {{ID_BITS{1'b0}}, r_in.group_id};
    assign item_key  = item_wide[ID_BITS-1:0];
    assign gid_key   = gid_wide[ID_BITS-1:0];

    assign rd_keys  = ram_rdata[KW-1:0];
    assign rd_done  = ram_rdata[KW +: MEMBERS];
    assign rd_valid = ram_rdata[KW+MEMBERS +: MEMBERS];
    assign rd_gkey  = ram_rdata[RW-1 -: ID_BITS];

    always_comb begin
        for (int m = 0; m < MEMBERS; m++) begin
            rd_hit[m] = rd_valid[m] && (rd_keys[m] == item_key);
        end
    end

    assign row_found   = r_gvalid[r_ev_idx] && (|rd_hit);
    assign new_done    = rd_done | rd_hit;
    assign row_pending = |(rd_valid & ~rd_hit & ~rd_done);

    always_comb begin
        n_state   = r_state;
        n_scan    = r_scan;
        n_ev_on   = 1'b0;
        n_ev_idx  = r_ev_idx;
        n_gvalid  = r_gvalid;
        n_strobe  = 1'b0;
        n_out     = r_out;
        bld_ctl   = '0;
        ram_we    = 1'b0;
        ram_waddr = bld_slot;
        ram_wdata = {gid_key, bld_valid, {MEMBERS{1'b0}}, bld_keys};

        case (r_state)
            S_IDLE: begin
                n_scan = '0;
                if (accept) begin
                    if (i_item.command == CMD_COMPLETE) begin
                        n_state = S_SCAN;
                    end else if (!i_item.empty_list && bld_sts.fresh) begin
                        n_state = S_ALLOC;
                    end else begin
                        n_state = S_ADD;
                    end
                end
            end
            S_ALLOC: begin
                if (!r_gvalid[r_scan]) begin
                    bld_ctl.alloc = 1'b1;
                    n_state       = S_ADD;
                end else if (r_scan == LAST_SLOT) begin
                    bld_ctl.alloc     = 1'b1;
                    bld_ctl.alloc_ovf = 1'b1;
                    n_state           = S_ADD;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            S_ADD: begin
                n_state = S_IDLE;
                n_out   = '{status: ST_EMPTY_OK, reported_id: '0, reported_result: '0};
                if (r_in.empty_list) begin
                    bld_ctl.close = 1'b1;
                    n_strobe      = 1'b1;
                end else begin
                    bld_ctl.add = 1'b1;
                    if (r_in.last_member) begin
                        bld_ctl.close = 1'b1;
                        n_strobe      = 1'b1;
                        if (bld_sts.single) begin
                            n_out.status      = ST_SINGLE;
                            n_out.reported_id = key_to_field(item_key);
                        end else if (bld_sts.ovf) begin
                            n_out.status = ST_ADD_FAILED;
                        end else begin
                            ram_we             = 1'b1;
                            n_gvalid[bld_slot] = 1'b1;
                            n_out.status       = ST_GROUP_MADE;
                            n_out.reported_id  = key_to_field(gid_key);
                        end
                    end
                end
            end
            S_SCAN: begin
                n_ev_on  = 1'b1;
                n_ev_idx = r_scan;
                if (r_scan != LAST_SLOT) begin
                    n_scan = r_scan + 1'b1;
                end
                if (r_ev_on) begin
                    n_out = '{status: ST_NOT_ACCEPTED, reported_id: '0, reported_result: '0};
                    if (row_found) begin
                        n_state  = S_IDLE;
                        n_strobe = 1'b1;
                        if (r_in.action_result != '0) begin
                            n_out.status          = ST_FINISHED;
                            n_out.reported_id     = key_to_field(rd_gkey);
                            n_out.reported_result = r_in.action_result;
                        end else if (row_pending) begin
                            ram_we       = 1'b1;
                            ram_waddr    = r_ev_idx;
                            ram_wdata    = {rd_gkey, rd_valid, new_done, rd_keys};
                            n_out.status = ST_ACCEPTED;
                        end else begin
                            n_gvalid[r_ev_idx] = 1'b0;
                            n_out.status       = ST_FINISHED;
                            n_out.reported_id  = key_to_field(rd_gkey);
                        end
                    end else if (r_ev_idx == LAST_SLOT) begin
                        n_state  = S_IDLE;
                        n_strobe = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_scan   <= '0;
            r_ev_on  <= 1'b0;
            r_ev_idx <= '0;
            r_gvalid <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_scan   <= n_scan;
            r_ev_on  <= n_ev_on;
            r_ev_idx <= n_ev_idx;
            r_gvalid <= n_gvalid;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_item;
        end
        r_out <= n_out;
    end

    cgt_list_builder #(
        .MEMBERS (MEMBERS),
        .ID_BITS (ID_BITS),
        .AW      (AW)
    ) u_builder (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (bld_ctl),
        .i_slot      (r_scan),
        .i_id        (item_key),
        .o_sts       (bld_sts),
        .o_slot      (bld_slot),
        .o_row_valid (bld_valid),
        .o_row_keys  (bld_keys)
    );

    cgt_row_ram #(
        .DEPTH (GROUPS),
        .WIDTH (RW),
        .AW    (AW)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_scan),
        .o_rdata (ram_rdata)
    );

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule
